### sv/i2p_pkg.sv
// Package: operator codes, precedence tables and character decode for the converter.
`timescale 1ns / 1ps

package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam int CODE_W = 3;
  localparam int PREC_W = 7;
  localparam int SYM_W  = 8;
  localparam int STAT_W = 2;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [PREC_W-1:0] prec_t;

  localparam code_t OP_PLUS  = 3'd0;
  localparam code_t OP_MINUS = 3'd1;
  localparam code_t OP_MUL   = 3'd2;
  localparam code_t OP_MOD   = 3'd3;
  localparam code_t OP_DIV   = 3'd4;
  localparam code_t OP_POW   = 3'd5;
  localparam code_t OP_OPEN  = 3'd6;
  localparam code_t OP_NONE  = 3'd7;

  localparam stat_t ST_SYMBOL   = 2'd0;
  localparam stat_t ST_DONE     = 2'd1;
  localparam stat_t ST_UNBAL    = 2'd2;
  localparam stat_t ST_OVERFLOW = 2'd3;

  localparam sym_t CH_PLUS  = 8'h2B;
  localparam sym_t CH_MINUS = 8'h2D;
  localparam sym_t CH_MUL   = 8'h2A;
  localparam sym_t CH_MOD   = 8'h25;
  localparam sym_t CH_DIV   = 8'h2F;
  localparam sym_t CH_POW   = 8'h5E;
  localparam sym_t CH_OPEN  = 8'h28;
  localparam sym_t CH_CLOSE = 8'h29;

  function automatic code_t op_code(input sym_t c);
    case (c)
      CH_PLUS:  op_code = OP_PLUS;
      CH_MINUS: op_code = OP_MINUS;
      CH_MUL:   op_code = OP_MUL;
      CH_MOD:   op_code = OP_MOD;
      CH_DIV:   op_code = OP_DIV;
      CH_POW:   op_code = OP_POW;
      CH_OPEN:  op_code = OP_OPEN;
      default:  op_code = OP_NONE;
    endcase
  endfunction

  function automatic logic is_operand(input sym_t c);
    is_operand = (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
                 (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic sym_t op_char(input code_t k);
    case (k)
      OP_PLUS:  op_char = CH_PLUS;
      OP_MINUS: op_char = CH_MINUS;
      OP_MUL:   op_char = CH_MUL;
      OP_MOD:   op_char = CH_MOD;
      OP_DIV:   op_char = CH_DIV;
      OP_POW:   op_char = CH_POW;
      default:  op_char = CH_OPEN;
    endcase
  endfunction

  function automatic prec_t prec_in(input code_t k);
    case (k)
      OP_PLUS, OP_MINUS:        prec_in = 7'd2;
      OP_MUL, OP_MOD, OP_DIV:   prec_in = 7'd4;
      OP_POW:                   prec_in = 7'd5;
      default:                  prec_in = 7'd0;
    endcase
  endfunction

  function automatic prec_t prec_out(input code_t k);
    case (k)
      OP_PLUS, OP_MINUS:        prec_out = 7'd1;
      OP_MUL, OP_MOD, OP_DIV:   prec_out = 7'd3;
      OP_POW:                   prec_out = 7'd6;
      default:                  prec_out = 7'd100;
    endcase
  endfunction

endpackage

### sv/i2p_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/infix_to_postfix_converter.sv
// Top level: shunting-yard infix to postfix converter with RAM operator stack.
//
// Input channel (in_valid/in_ready): one ASCII symbol per transaction, or an
// end-of-expression transaction with finish set. Operands pass out at once,
// operators are held on a stack of STACK_DEPTH entries and leave in postfix
// order. The end transaction flushes the stack and closes with one status
// result (complete or unbalanced parenthesis; overflow comes from a push).
// Output channel (out_valid/out_ready): out_symbol, status, last; last marks
// the final result caused by one input transaction.
// Timing: in_ready is high only while the sequencer is idle. Each operator
// pop costs a stack RAM read (registered, state S_WAIT) and a decision in
// state S_TOP. Results are held back one step so that last can be set on
// the final one.
// A stalled receiver holds the output register; the sequencer then waits
// before producing the next result. Reset (rst, synchronous) empties the
// stack and clears the error/discard flag; RAM contents need no clearing.
`timescale 1ns / 1ps

module infix_to_postfix_converter
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] symbol,
  input  logic       finish,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output logic [1:0] status,
  output logic       last
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_WAIT, S_TOP, S_DRAIN} state_t;
  typedef enum logic [1:0] {M_FLUSH, M_OPER, M_CLOSE} mode_t;

  state_t           state, state_next;
  mode_t            mode, mode_next;
  code_t            code, code_next;
  logic [CNT_W-1:0] count, count_next;
  logic             discarding, discarding_next;
  logic             pend_valid, pend_valid_next;
  sym_t             pend_sym, pend_sym_next;
  stat_t            pend_stat, pend_stat_next;
  logic             out_valid_next;
  sym_t             out_symbol_next;
  stat_t            status_next;
  logic             last_next;

  logic             ram_we;
  logic [CNT_W-1:0] top_idx;
  code_t            rdata;
  code_t            top;
  logic             empty;
  logic             slot_free;
  logic             stall;
  logic             produce;
  sym_t             prod_sym;
  stat_t            prod_stat;
  code_t            in_code;

  assign top_idx   = count - CNT_W'(1);
  assign top       = (rdata > OP_OPEN) ? OP_OPEN : rdata;
  assign empty     = (count == '0);
  assign slot_free = !out_valid || out_ready;
  assign stall     = pend_valid && !slot_free;
  assign in_ready  = (state == S_IDLE);
  assign in_code   = op_code(symbol);

  i2p_ram #(
    .WIDTH(CODE_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(code),
    .raddr(top_idx[ADDR_W-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    state_next      = state;
    mode_next       = mode;
    code_next       = code;
    count_next      = count;
    discarding_next = discarding;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;
    pend_stat_next  = pend_stat;
    out_valid_next  = out_valid && !out_ready;
    out_symbol_next = out_symbol;
    status_next     = status;
    last_next       = last;
    ram_we          = 1'b0;
    produce         = 1'b0;
    prod_sym        = '0;
    prod_stat       = ST_SYMBOL;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          code_next = in_code;
          if (finish) begin
            if (discarding) begin
              pend_valid_next = 1'b1;
              pend_sym_next   = '0;
              pend_stat_next  = ST_DONE;
              count_next      = '0;
              discarding_next = 1'b0;
              state_next      = S_DRAIN;
            end else begin
              mode_next  = M_FLUSH;
              state_next = S_TOP;
            end
          end else if (!discarding) begin
            if (is_operand(symbol)) begin
              pend_valid_next = 1'b1;
              pend_sym_next   = symbol;
              pend_stat_next  = ST_SYMBOL;
              state_next      = S_DRAIN;
            end else if (in_code != OP_NONE) begin
              mode_next  = M_OPER;
              state_next = S_TOP;
            end else if (symbol == CH_CLOSE) begin
              mode_next  = M_CLOSE;
              state_next = S_TOP;
            end
          end
        end
      end
      S_WAIT: begin
        state_next = S_TOP;
      end
      S_TOP: begin
        if (!stall) begin
          case (mode)
            M_FLUSH: begin
              produce = 1'b1;
              if (empty) begin
                prod_stat       = ST_DONE;
                discarding_next = 1'b0;
                state_next      = S_DRAIN;
              end else if (top == OP_OPEN) begin
                prod_stat       = ST_UNBAL;
                count_next      = '0;
                discarding_next = 1'b0;
                state_next      = S_DRAIN;
              end else begin
                prod_sym   = op_char(top);
                count_next = top_idx;
                state_next = S_WAIT;
              end
            end
            M_OPER: begin
              if (!empty && prec_out(code) < prec_in(top)) begin
                produce    = 1'b1;
                prod_sym   = op_char(top);
                count_next = top_idx;
                state_next = S_WAIT;
              end else if (count == CNT_W'(STACK_DEPTH)) begin
                produce         = 1'b1;
                prod_stat       = ST_OVERFLOW;
                count_next      = '0;
                discarding_next = 1'b1;
                state_next      = S_DRAIN;
              end else begin
                ram_we     = 1'b1;
                count_next = count + CNT_W'(1);
                state_next = S_DRAIN;
              end
            end
            default: begin
              if (empty) begin
                produce         = 1'b1;
                prod_stat       = ST_UNBAL;
                discarding_next = 1'b1;
                state_next      = S_DRAIN;
              end else begin
                count_next = top_idx;
                if (top == OP_OPEN) begin
                  state_next = S_DRAIN;
                end else begin
                  produce    = 1'b1;
                  prod_sym   = op_char(top);
                  state_next = S_WAIT;
                end
              end
            end
          endcase
        end
      end
      default: begin
        // hand the held-back result out as the final one
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (slot_free) begin
          out_valid_next  = 1'b1;
          out_symbol_next = pend_sym;
          status_next     = pend_stat;
          last_next       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
    endcase

    if (produce) begin
      if (pend_valid) begin
        out_valid_next  = 1'b1;
        out_symbol_next = pend_sym;
        status_next     = pend_stat;
        last_next       = 1'b0;
      end
      pend_valid_next = 1'b1;
      pend_sym_next   = prod_sym;
      pend_stat_next  = prod_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= M_FLUSH;
      count      <= '0;
      discarding <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      count      <= count_next;
      discarding <= discarding_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
    code       <= code_next;
    pend_sym   <= pend_sym_next;
    pend_stat  <= pend_stat_next;
    out_symbol <= out_symbol_next;
    status     <= status_next;
    last       <= last_next;
  end

endmodule
